// ===== sv/rgu_pkg.sv =====
`default_nettype none

package rgu_pkg;

    // Default layer sizes
    localparam int VISIBLE_UNITS_DEF = 64;
    localparam int HIDDEN_UNITS_DEF  = 64;
    localparam int LABEL_UNITS_DEF   = 32;

    // Accumulator width: 16-bit bias plus up to 128 16-bit weights
    localparam int ACC_W = 24;

    // Sigmoid half table: p(k) for k = 0..512
    localparam int SIG_DEPTH = 513;
    localparam int SIG_AW    = 10;
    localparam int SIG_HALF  = 512;

    // e^(-1/64) in Q0.32
    localparam logic [31:0] EXP_STEP = 32'd4228380000;

    typedef enum logic [3:0] {
        OP_WR_VH   = 4'd0,
        OP_WR_LH   = 4'd1,
        OP_WR_VB   = 4'd2,
        OP_WR_HB   = 4'd3,
        OP_WR_LB   = 4'd4,
        OP_SET_VIS = 4'd5,
        OP_SET_LAB = 4'd6,
        OP_SMP_HID = 4'd7,
        OP_SMP_VIS = 4'd8,
        OP_SMP_LAB = 4'd9
    } opcode_t;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [5:0]         row_index;
        logic [5:0]         column_index;
        logic signed [15:0] write_value;
        logic [15:0]        uniform_random;
    } in_t;

    typedef struct packed {
        logic [15:0]        probability;
        logic               sampled_bit;
        logic signed [15:0] net_input;
    } out_t;

    // Table write from the init sequencer
    typedef struct packed {
        logic              we;
        logic [SIG_AW-1:0] addr;
        logic [15:0]       data;
    } sig_wr_t;

    typedef enum logic [2:0] {
        INIT_SETUP,
        INIT_DIV,
        INIT_WRITE,
        INIT_STEP,
        INIT_DONE
    } init_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_SUM,
        ST_DRAIN,
        ST_LOOK,
        ST_PROB,
        ST_DONE
    } smp_state_t;

endpackage

`default_nettype wire

// ===== sv/rgu_ram.sv =====
`default_nettype none

module rgu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/rgu_sig_init.sv =====
`default_nettype none

module rgu_sig_init import rgu_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    output sig_wr_t   sig_wr,
    output logic      done
);

    init_state_t state_reg, state_next;

    logic [SIG_AW-1:0] k_reg, k_next;
    logic [32:0]       ek_reg, ek_next;
    logic [48:0]       rem_reg, rem_next;
    logic [49:0]       dsh_reg, dsh_next;
    logic [16:0]       q_reg, q_next;
    logic [4:0]        bit_reg, bit_next;
    logic [64:0]       prod_reg, prod_next;

    logic [33:0] d_val;
    logic        ge;
    logic [64:0] rnd_sum;

    // d = 2^32 + e_k
    assign d_val   = 34'(ek_reg) + 34'h1_0000_0000;
    assign ge      = {1'b0, rem_reg} >= dsh_reg;
    assign rnd_sum = prod_reg + 65'(64'h8000_0000);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            INIT_SETUP: state_next = INIT_DIV;
            INIT_DIV:   if (bit_reg == 5'd0) state_next = INIT_WRITE;
            INIT_WRITE: state_next = INIT_STEP;
            INIT_STEP:  state_next = (k_reg == SIG_AW'(SIG_HALF)) ? INIT_DONE : INIT_SETUP;
            INIT_DONE:  state_next = INIT_DONE;
            default:    state_next = INIT_SETUP;
        endcase
    end

    // Outputs
    always_comb begin
        sig_wr.we   = (state_reg == INIT_WRITE);
        sig_wr.addr = k_reg;
        sig_wr.data = q_reg[15:0];
        done        = (state_reg == INIT_DONE);
    end

    // Datapath: restoring divide, then e_k update through the multiplier
    always_comb begin
        k_next    = k_reg;
        ek_next   = ek_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        bit_next  = bit_reg;
        prod_next = prod_reg;
        case (state_reg)
            INIT_SETUP: begin
                rem_next = {1'b1, 48'd0} + 49'(d_val[33:1]);
                dsh_next = {d_val, 16'd0};
                q_next   = '0;
                bit_next = 5'd16;
            end
            INIT_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - dsh_reg[48:0];
                end
                q_next   = {q_reg[15:0], ge};
                dsh_next = {1'b0, dsh_reg[49:1]};
                bit_next = bit_reg - 5'd1;
            end
            INIT_WRITE: begin
                prod_next = 65'(ek_reg) * 65'(EXP_STEP);
            end
            INIT_STEP: begin
                ek_next = rnd_sum[64:32];
                k_next  = k_reg + SIG_AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= INIT_SETUP;
            k_reg     <= '0;
            ek_reg    <= {1'b1, 32'd0};
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ek_reg    <= ek_next;
        end
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        bit_reg  <= bit_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

// ===== sv/rbm_gibbs_unit_sampler.sv =====
`default_nettype none

// Conditional RBM Gibbs sampler, one transaction per item. After reset the block
// builds its sigmoid table (513 entries) with s_ready low. Write, bit and unused
// opcodes, and samples with an out-of-range row, go straight to the result
// state; m_valid rises and s_ready returns together once the output register is
// free. A hidden sample sums the bias and VISIBLE_UNITS + LABEL_UNITS weights, a
// visible or label sample the bias and HIDDEN_UNITS weights, in bias, sum,
// drain, look-up, probability and result states; the single accumulator takes
// one weight read per cycle from the weight memories. One transaction is in
// flight at a time; a finished result sits in the output register while the
// next one is taken, and a result that cannot leave holds off the next input.
module rbm_gibbs_unit_sampler import rgu_pkg::*; #(
    parameter int VISIBLE_UNITS = VISIBLE_UNITS_DEF,
    parameter int HIDDEN_UNITS  = HIDDEN_UNITS_DEF,
    parameter int LABEL_UNITS   = LABEL_UNITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int VH_DEPTH = VISIBLE_UNITS * HIDDEN_UNITS;
    localparam int LH_DEPTH = LABEL_UNITS * HIDDEN_UNITS;
    localparam int VH_AW = (VH_DEPTH > 1) ? $clog2(VH_DEPTH) : 1;
    localparam int LH_AW = (LH_DEPTH > 1) ? $clog2(LH_DEPTH) : 1;
    localparam int VB_AW = (VISIBLE_UNITS > 1) ? $clog2(VISIBLE_UNITS) : 1;
    localparam int HB_AW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int LB_AW = (LABEL_UNITS > 1) ? $clog2(LABEL_UNITS) : 1;
    localparam int MAXN  = (VISIBLE_UNITS + LABEL_UNITS > HIDDEN_UNITS) ?
                           VISIBLE_UNITS + LABEL_UNITS : HIDDEN_UNITS;
    localparam int CW    = $clog2(MAXN + 1);

    smp_state_t state_reg, state_next;

    logic [3:0]        op_reg;
    logic [5:0]        row_reg;
    logic [15:0]       rnd_reg;
    logic [CW-1:0]     cnt_reg, total_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic              pend_reg, pend_lab_reg;
    logic signed [15:0] pre_reg;
    logic              neg_reg;
    out_t              res_reg;
    out_t              m_data_reg;
    logic              m_valid_reg;
    logic [VISIBLE_UNITS-1:0] vis_bits_reg;
    logic [HIDDEN_UNITS-1:0]  hid_bits_reg;
    logic [LABEL_UNITS-1:0]   lab_bits_reg;

    logic    init_done;
    sig_wr_t sig_wr;

    logic accept, sample_ok, out_free, last_issue;
    logic do_issue, do_drain, do_look, do_prob, do_deliver;
    logic hsmp, use_lab, sel_bit;
    logic row_lt_vis, row_lt_hid, row_lt_lab, col_lt_vis, col_lt_lab;

    logic [VH_AW-1:0] vh_waddr, vh_raddr;
    logic [LH_AW-1:0] lh_waddr, lh_raddr;
    logic [15:0]      vh_rdata, lh_rdata, vb_rdata, hb_rdata, lb_rdata, sig_rdata;
    logic [15:0]      bias_sel, w_sel;
    logic signed [15:0] sat;
    logic [SIG_AW-1:0]  sig_idx, sig_raddr;
    logic [15:0]        prob;
    logic               smp_bit;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Range checks on the incoming transaction
    assign row_lt_vis = {1'b0, s_data.row_index} < 7'(VISIBLE_UNITS);
    assign row_lt_hid = {1'b0, s_data.row_index} < 7'(HIDDEN_UNITS);
    assign row_lt_lab = {1'b0, s_data.row_index} < 7'(LABEL_UNITS);
    assign col_lt_vis = {1'b0, s_data.column_index} < 7'(VISIBLE_UNITS);
    assign col_lt_lab = {1'b0, s_data.column_index} < 7'(LABEL_UNITS);

    assign sample_ok = (s_data.opcode == OP_SMP_HID && row_lt_hid) ||
                       (s_data.opcode == OP_SMP_VIS && row_lt_vis) ||
                       (s_data.opcode == OP_SMP_LAB && row_lt_lab);

    assign last_issue = (cnt_reg == total_reg - CW'(1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = sample_ok ? ST_BIAS : ST_DONE;
            ST_BIAS:  state_next = ST_SUM;
            ST_SUM:   if (last_issue) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_PROB;
            ST_PROB:  state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready    = (state_reg == ST_IDLE) && init_done;
        do_issue   = (state_reg == ST_SUM);
        do_drain   = (state_reg == ST_DRAIN);
        do_look    = (state_reg == ST_LOOK);
        do_prob    = (state_reg == ST_PROB);
        do_deliver = (state_reg == ST_DONE) && out_free;
    end

    // Weight addressing: row walk for hidden, column walk for visible/label
    assign hsmp    = (op_reg == OP_SMP_HID);
    assign use_lab = hsmp ? ({1'b0, cnt_reg} >= (CW+1)'(VISIBLE_UNITS))
                          : (op_reg == OP_SMP_LAB);

    assign vh_raddr = hsmp ?
        VH_AW'(int'(row_reg) * VISIBLE_UNITS + int'(cnt_reg)) :
        VH_AW'(int'(cnt_reg) * VISIBLE_UNITS + int'(row_reg));
    assign lh_raddr = hsmp ?
        LH_AW'(int'(row_reg) * LABEL_UNITS + int'(cnt_reg) - VISIBLE_UNITS) :
        LH_AW'(int'(cnt_reg) * LABEL_UNITS + int'(row_reg));

    assign vh_waddr = VH_AW'(int'(s_data.row_index) * VISIBLE_UNITS +
                             int'(s_data.column_index));
    assign lh_waddr = LH_AW'(int'(s_data.row_index) * LABEL_UNITS +
                             int'(s_data.column_index));

    // Unit bit for the element being issued
    always_comb begin
        sel_bit = 1'b0;
        for (int j = 0; j < VISIBLE_UNITS; j++) begin
            if (hsmp && cnt_reg == CW'(j)) sel_bit = vis_bits_reg[j];
        end
        for (int j = 0; j < LABEL_UNITS; j++) begin
            if (hsmp && cnt_reg == CW'(VISIBLE_UNITS + j)) sel_bit = lab_bits_reg[j];
        end
        for (int j = 0; j < HIDDEN_UNITS; j++) begin
            if (!hsmp && cnt_reg == CW'(j)) sel_bit = hid_bits_reg[j];
        end
    end

    // Bias and weight selection
    always_comb begin
        case (op_reg)
            OP_SMP_HID: bias_sel = hb_rdata;
            OP_SMP_VIS: bias_sel = vb_rdata;
            default:    bias_sel = lb_rdata;
        endcase
        w_sel = pend_lab_reg ? lh_rdata : vh_rdata;
    end

    // Shared accumulator
    always_comb begin
        acc_next = acc_reg;
        if (do_issue && cnt_reg == '0) begin
            acc_next = ACC_W'($signed(bias_sel));
        end else if ((do_issue || do_drain) && pend_reg) begin
            acc_next = acc_reg + ACC_W'($signed(w_sel));
        end
    end

    // Saturate and form the half-table address
    always_comb begin
        if (acc_reg > ACC_W'(32767)) begin
            sat = 16'sh7fff;
        end else if (acc_reg < -ACC_W'(32768)) begin
            sat = -16'sh8000;
        end else begin
            sat = acc_reg[15:0];
        end
        sig_idx   = {~sat[15], sat[14:6]};
        sig_raddr = sig_idx[SIG_AW-1] ? {1'b0, sig_idx[SIG_AW-2:0]}
                                      : SIG_AW'(SIG_HALF) - sig_idx;
    end

    // Mirror the lower half and compare against the threshold
    assign prob    = neg_reg ? 16'(17'h10000 - 17'(sig_rdata)) : sig_rdata;
    assign smp_bit = rnd_reg < prob;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (do_deliver) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_BIAS) begin
                cnt_reg <= '0;
            end else if (do_issue) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // Layer bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_bits_reg <= '0;
            hid_bits_reg <= '0;
            lab_bits_reg <= '0;
        end else begin
            for (int j = 0; j < VISIBLE_UNITS; j++) begin
                if (accept && s_data.opcode == OP_SET_VIS && s_data.row_index == 6'(j))
                    vis_bits_reg[j] <= s_data.write_value[0];
                if (do_prob && op_reg == OP_SMP_VIS && row_reg == 6'(j))
                    vis_bits_reg[j] <= smp_bit;
            end
            for (int j = 0; j < LABEL_UNITS; j++) begin
                if (accept && s_data.opcode == OP_SET_LAB && s_data.row_index == 6'(j))
                    lab_bits_reg[j] <= s_data.write_value[0];
                if (do_prob && op_reg == OP_SMP_LAB && row_reg == 6'(j))
                    lab_bits_reg[j] <= smp_bit;
            end
            for (int j = 0; j < HIDDEN_UNITS; j++) begin
                if (do_prob && op_reg == OP_SMP_HID && row_reg == 6'(j))
                    hid_bits_reg[j] <= smp_bit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_data.opcode;
            row_reg   <= s_data.row_index;
            rnd_reg   <= s_data.uniform_random;
            total_reg <= (s_data.opcode == OP_SMP_HID) ?
                         CW'(VISIBLE_UNITS + LABEL_UNITS) : CW'(HIDDEN_UNITS);
            res_reg   <= '0;
        end
        if (do_issue) begin
            pend_reg     <= sel_bit;
            pend_lab_reg <= use_lab;
        end
        acc_reg <= acc_next;
        if (do_look) begin
            pre_reg <= sat;
            neg_reg <= !sig_idx[SIG_AW-1];
        end
        if (do_prob) begin
            res_reg.probability <= prob;
            res_reg.sampled_bit <= smp_bit;
            res_reg.net_input   <= pre_reg;
        end
        if (do_deliver) begin
            m_data_reg <= res_reg;
        end
    end

    // Parameter memories
    rgu_ram #(.WIDTH(16), .DEPTH(VH_DEPTH)) u_vh_ram (
        .aclk (aclk),
        .we   (accept && s_data.opcode == OP_WR_VH && row_lt_hid && col_lt_vis),
        .waddr(vh_waddr),
        .wdata(s_data.write_value),
        .raddr(vh_raddr),
        .rdata(vh_rdata)
    );

    rgu_ram #(.WIDTH(16), .DEPTH(LH_DEPTH)) u_lh_ram (
        .aclk (aclk),
        .we   (accept && s_data.opcode == OP_WR_LH && row_lt_hid && col_lt_lab),
        .waddr(lh_waddr),
        .wdata(s_data.write_value),
        .raddr(lh_raddr),
        .rdata(lh_rdata)
    );

    rgu_ram #(.WIDTH(16), .DEPTH(VISIBLE_UNITS)) u_vb_ram (
        .aclk (aclk),
        .we   (accept && s_data.opcode == OP_WR_VB && row_lt_vis),
        .waddr(VB_AW'(s_data.row_index)),
        .wdata(s_data.write_value),
        .raddr(VB_AW'(row_reg)),
        .rdata(vb_rdata)
    );

    rgu_ram #(.WIDTH(16), .DEPTH(HIDDEN_UNITS)) u_hb_ram (
        .aclk (aclk),
        .we   (accept && s_data.opcode == OP_WR_HB && row_lt_hid),
        .waddr(HB_AW'(s_data.row_index)),
        .wdata(s_data.write_value),
        .raddr(HB_AW'(row_reg)),
        .rdata(hb_rdata)
    );

    rgu_ram #(.WIDTH(16), .DEPTH(LABEL_UNITS)) u_lb_ram (
        .aclk (aclk),
        .we   (accept && s_data.opcode == OP_WR_LB && row_lt_lab),
        .waddr(LB_AW'(s_data.row_index)),
        .wdata(s_data.write_value),
        .raddr(LB_AW'(row_reg)),
        .rdata(lb_rdata)
    );

    // Sigmoid half table and its builder
    rgu_ram #(.WIDTH(16), .DEPTH(SIG_DEPTH)) u_sig_ram (
        .aclk (aclk),
        .we   (sig_wr.we),
        .waddr(sig_wr.addr),
        .wdata(sig_wr.data),
        .raddr(sig_raddr),
        .rdata(sig_rdata)
    );

    rgu_sig_init u_sig_init (
        .aclk   (aclk),
        .aresetn(aresetn),
        .sig_wr (sig_wr),
        .done   (init_done)
    );

    // Checks
    a_no_accept_during_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready)
        else $error("input taken before sigmoid table built");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    a_bit_needs_prob: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sampled_bit) |-> (m_data.probability != 16'd0))
        else $error("sampled bit set with zero probability");

    a_prob_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        do_prob |=> (state_reg == ST_DONE))
        else $error("sequencer skipped result stage");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb import rgu_pkg::*; ;

    localparam int NVIS = VISIBLE_UNITS_DEF;
    localparam int NHID = HIDDEN_UNITS_DEF;
    localparam int NLAB = LABEL_UNITS_DEF;

    // Tracks the sampler state and the queue of results still owed by the DUT
    class sampler_board;
        int       w_vh[NHID][NVIS];
        int       w_lh[NHID][NLAB];
        int       b_vis[NVIS];
        int       b_hid[NHID];
        int       b_lab[NLAB];
        bit       vis_bit[NVIS];
        bit       hid_bit[NHID];
        bit       lab_bit[NLAB];
        bit [15:0] sigmoid[1024];
        out_t     owed[$];
        int       mismatches;

        function new();
            longint unsigned ek;
            longint unsigned d;
            longint unsigned pk[513];
            ek = 64'd1 << 32;
            for (int k = 0; k <= 512; k++) begin
                d = (64'd1 << 32) + ek;
                pk[k] = ((64'd1 << 48) + d / 2) / d;
                ek = (ek * 64'd4228380000 + (64'd1 << 31)) >> 32;
            end
            for (int k = 0; k < 512; k++) sigmoid[512 + k] = pk[k][15:0];
            for (int k = 1; k <= 512; k++) sigmoid[512 - k] = 16'(65536 - pk[k]);
            mismatches = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Apply one accepted transaction and queue its result
        function void note(in_t x);
            int   row;
            int   col;
            int   val;
            int   acc;
            int   idx;
            bit   smp;
            out_t r;
            row = x.row_index;
            col = x.column_index;
            val = x.write_value;
            smp = 0;
            acc = 0;
            r = '0;
            case (x.opcode)
                OP_WR_VH:   if (row < NHID && col < NVIS) w_vh[row][col] = val;
                OP_WR_LH:   if (row < NHID && col < NLAB) w_lh[row][col] = val;
                OP_WR_VB:   if (row < NVIS) b_vis[row] = val;
                OP_WR_HB:   if (row < NHID) b_hid[row] = val;
                OP_WR_LB:   if (row < NLAB) b_lab[row] = val;
                OP_SET_VIS: if (row < NVIS) vis_bit[row] = x.write_value[0];
                OP_SET_LAB: if (row < NLAB) lab_bit[row] = x.write_value[0];
                OP_SMP_HID: if (row < NHID) begin
                    acc = b_hid[row];
                    for (int i = 0; i < NVIS; i++) if (vis_bit[i]) acc += w_vh[row][i];
                    for (int i = 0; i < NLAB; i++) if (lab_bit[i]) acc += w_lh[row][i];
                    smp = 1;
                end
                OP_SMP_VIS: if (row < NVIS) begin
                    acc = b_vis[row];
                    for (int i = 0; i < NHID; i++) if (hid_bit[i]) acc += w_vh[i][row];
                    smp = 1;
                end
                OP_SMP_LAB: if (row < NLAB) begin
                    acc = b_lab[row];
                    for (int i = 0; i < NHID; i++) if (hid_bit[i]) acc += w_lh[i][row];
                    smp = 1;
                end
                default: ;
            endcase
            if (smp) begin
                if (acc > 32767) acc = 32767;
                if (acc < -32768) acc = -32768;
                idx = (acc + 32768) >> 6;
                r.net_input = 16'(acc);
                r.probability = sigmoid[idx];
                r.sampled_bit = (x.uniform_random < r.probability);
                if (x.opcode == OP_SMP_HID) hid_bit[row] = r.sampled_bit;
                else if (x.opcode == OP_SMP_VIS) vis_bit[row] = r.sampled_bit;
                else lab_bit[row] = r.sampled_bit;
            end
            owed.push_back(r);
        endfunction

        // Compare one result with the oldest owed one
        function void check(out_t got);
            out_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = owed.pop_front();
            if (got.probability !== want.probability || got.sampled_bit !== want.sampled_bit
                || got.net_input !== want.net_input) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp prob %h bit %b net %h, got prob %h bit %b net %h",
                             want.probability, want.sampled_bit, want.net_input,
                             got.probability, got.sampled_bit, got.net_input);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    sampler_board board = new();
    int snd_idle_pct;
    int rcv_idle_pct;

    rbm_gibbs_unit_sampler u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Result side: check on handshake, then pick next ready
    always @(posedge aclk) begin
        if (m_valid && m_ready) board.check(m_data);
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin
        #30ms;
        $display("FAIL rbm_gibbs_unit_sampler");
        $finish;
    end

    function automatic in_t mk(int op, int row, int col, logic [15:0] val,
                               logic [15:0] rnd);
        in_t x;
        x.opcode = 4'(op);
        x.row_index = 6'(row);
        x.column_index = 6'(col);
        x.write_value = val;
        x.uniform_random = rnd;
        return x;
    endfunction

    // Mostly modest weights so sums land on the slope, sometimes full range
    function automatic logic [15:0] rand_w();
        if ($urandom_range(7) == 0) return 16'($urandom);
        return 16'($urandom_range(2047) - 1024);
    endfunction

    task automatic send(in_t x);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        do @(posedge aclk); while (!s_ready);
        board.note(x);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic random_item();
        int pick;
        int op;
        pick = $urandom_range(99);
        if (pick < 40) begin
            op = $urandom_range(OP_SMP_HID, OP_SMP_LAB);
            send(mk(op, (op == OP_SMP_LAB) ? $urandom_range(NLAB - 1) : $urandom_range(63),
                    $urandom_range(63), 16'($urandom), 16'($urandom)));
        end else if (pick < 58) begin
            op = $urandom_range(OP_SET_VIS, OP_SET_LAB);
            send(mk(op, (op == OP_SET_LAB) ? $urandom_range(NLAB - 1) : $urandom_range(63),
                    $urandom_range(63), 16'($urandom), 16'($urandom)));
        end else if (pick < 90) begin
            op = $urandom_range(OP_WR_VH, OP_WR_LB);
            send(mk(op, (op == OP_WR_LB) ? $urandom_range(NLAB - 1) : $urandom_range(63),
                    (op == OP_WR_LH) ? $urandom_range(NLAB - 1) : $urandom_range(63),
                    rand_w(), 16'($urandom)));
        end else begin
            // noise: any opcode, with row and column indexes beyond the label range
            op = $urandom_range(15);
            send(mk(op, $urandom_range(NLAB, 63), $urandom_range(NLAB, 63),
                    16'($urandom), 16'($urandom)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Preload every parameter so no sample ever reads an unwritten entry
        for (int h = 0; h < NHID; h++) begin
            for (int v = 0; v < NVIS; v++) send(mk(OP_WR_VH, h, v, rand_w(), 16'($urandom)));
            for (int l = 0; l < NLAB; l++) send(mk(OP_WR_LH, h, l, rand_w(), 16'($urandom)));
            send(mk(OP_WR_HB, h, 0, rand_w(), 16'($urandom)));
        end
        for (int v = 0; v < NVIS; v++) send(mk(OP_WR_VB, v, 0, rand_w(), 16'($urandom)));
        for (int l = 0; l < NLAB; l++) send(mk(OP_WR_LB, l, 0, rand_w(), 16'($urandom)));

        // Directed: bias extremes with all bits clear, then saturation both ways
        send(mk(OP_WR_HB, 0, 0, 16'h7FFF, 16'h0));
        send(mk(OP_SMP_HID, 0, 0, 16'h0, 16'h0000));
        send(mk(OP_WR_HB, 1, 0, 16'h8000, 16'h0));
        send(mk(OP_SMP_HID, 1, 0, 16'h0, 16'hFFFF));
        send(mk(OP_SET_VIS, 0, 0, 16'h0001, 16'h0));
        send(mk(OP_WR_VH, 0, 0, 16'h7FFF, 16'h0));
        send(mk(OP_WR_VH, 1, 0, 16'h8000, 16'h0));
        send(mk(OP_SMP_HID, 0, 0, 16'h0, 16'hFFFF));
        send(mk(OP_SMP_HID, 1, 0, 16'h0, 16'h0000));
        send(mk(OP_SET_LAB, NLAB - 1, 0, 16'hFFFF, 16'h0));
        send(mk(OP_SMP_HID, 63, 63, 16'h0, 16'h8000));
        send(mk(OP_SMP_VIS, 63, 0, 16'h0, 16'h7FFF));
        send(mk(OP_SMP_LAB, NLAB - 1, 0, 16'h0, 16'h1234));
        // bit writes look at bit zero only
        send(mk(OP_SET_VIS, 0, 0, 16'hFFFE, 16'h0));
        // out-of-range label row and column
        send(mk(OP_WR_LH, 5, NLAB, 16'h1000, 16'h0));
        send(mk(OP_WR_LB, 40, 0, 16'h1000, 16'h0));
        send(mk(OP_SET_LAB, 63, 0, 16'h0001, 16'h0));
        send(mk(OP_SMP_LAB, NLAB, 0, 16'h0, 16'h0));
        // unused opcodes
        for (int k = OP_SMP_LAB + 1; k < 16; k++)
            send(mk(k, 63, 63, 16'hFFFF, 16'hFFFF));

        // Random phases with different idling profiles
        snd_idle_pct = 8;
        rcv_idle_pct = 86;
        repeat (420) random_item();
        drain();
        snd_idle_pct = 86;
        rcv_idle_pct = 8;
        repeat (400) random_item();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        repeat (430) random_item();

        drain();
        repeat (150) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASS rbm_gibbs_unit_sampler");
        end else begin
            $display("FAIL rbm_gibbs_unit_sampler");
        end
        $finish;
    end
endmodule
